### src/rora_pkg.sv
// Shared types and constants for the rectangle overlap ratio unit.
// No dependencies.
`default_nettype none
package rora_pkg;
	localparam int COORD_BITS = 15;
	localparam int FRAC_BITS  = 16;
	localparam int HULL_BITS  = COORD_BITS + 1;
	localparam int AREA_BITS  = 2 * HULL_BITS + 1;
	localparam int RATIO_BITS = FRAC_BITS + 1;

	typedef struct packed {
		logic [COORD_BITS-1:0] a_left;
		logic [COORD_BITS-1:0] a_top;
		logic [COORD_BITS-1:0] a_width;
		logic [COORD_BITS-1:0] a_height;
		logic [COORD_BITS-1:0] b_left;
		logic [COORD_BITS-1:0] b_top;
		logic [COORD_BITS-1:0] b_width;
		logic [COORD_BITS-1:0] b_height;
	} req_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] inter_left;
		logic [COORD_BITS-1:0] inter_top;
		logic [COORD_BITS-1:0] inter_width;
		logic [COORD_BITS-1:0] inter_height;
		logic [COORD_BITS-1:0] hull_left;
		logic [COORD_BITS-1:0] hull_top;
		logic [HULL_BITS-1:0]  hull_width;
		logic [HULL_BITS-1:0]  hull_height;
		logic [RATIO_BITS-1:0] overlap_ratio;
		logic                  same_rect;
	} rsp_t;

	// geometry carried alongside the divider
	typedef struct packed {
		logic [COORD_BITS-1:0] inter_left;
		logic [COORD_BITS-1:0] inter_top;
		logic [COORD_BITS-1:0] inter_width;
		logic [COORD_BITS-1:0] inter_height;
		logic [COORD_BITS-1:0] hull_left;
		logic [COORD_BITS-1:0] hull_top;
		logic [HULL_BITS-1:0]  hull_width;
		logic [HULL_BITS-1:0]  hull_height;
		logic                  same_rect;
	} geom_t;
endpackage
`default_nettype wire

### src/rora_div.sv
// Pipelined restoring fraction divider, one quotient bit per stage.
// Depends on rora_pkg. Advances when en is high; valid travels with data.
`default_nettype none
module rora_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           in_valid,
	input  wire logic [rora_pkg::AREA_BITS-1:0] num,
	input  wire logic [rora_pkg::AREA_BITS-1:0] den,
	input  wire rora_pkg::geom_t                in_geom,
	output logic                                out_valid,
	output logic [rora_pkg::RATIO_BITS-1:0]     quo,
	output rora_pkg::geom_t                     out_geom
);
	localparam int N = rora_pkg::FRAC_BITS + 1;
	localparam int AB = rora_pkg::AREA_BITS;
	localparam int QB = rora_pkg::RATIO_BITS;

	logic [N-1:0]        vld_q;
	logic [AB-1:0]       rem_q [N];
	logic [AB-1:0]       den_q [N];
	logic [QB-1:0]       quo_q [N];
	rora_pkg::geom_t     geo_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[N-2:0], in_valid};
		end
	end

	// stage 0 takes the integer bit, later stages one fraction bit each
	always_ff @(posedge clk) begin
		if (en) begin
			if (num >= den) begin
				rem_q[0] <= num - den;
				quo_q[0] <= QB'(1);
			end else begin
				rem_q[0] <= num;
				quo_q[0] <= '0;
			end
			den_q[0] <= den;
			geo_q[0] <= in_geom;
			for (int i = 1; i < N; i++) begin
				if (rem_q[i-1] >= den_q[i-1] - rem_q[i-1]) begin
					rem_q[i] <= rem_q[i-1] - (den_q[i-1] - rem_q[i-1]);
					quo_q[i] <= {quo_q[i-1][QB-2:0], 1'b1};
				end else begin
					rem_q[i] <= {rem_q[i-1][AB-2:0], 1'b0};
					quo_q[i] <= {quo_q[i-1][QB-2:0], 1'b0};
				end
				den_q[i] <= den_q[i-1];
				geo_q[i] <= geo_q[i-1];
			end
		end
	end

	assign out_valid = vld_q[N-1];
	assign quo       = quo_q[N-1];
	assign out_geom  = geo_q[N-1];
endmodule
`default_nettype wire

### src/rect_overlap_ratio_unit.sv
// Top level of the rectangle overlap ratio unit.
// Depends on rora_pkg and rora_div.
//
// Computes intersection, hull, smoothed overlap ratio (inter+1)/(hull+1) with
// FRAC_BITS fraction bits, and an equality flag for two rectangles. Fully
// pipelined: one request per cycle, through two geometry stages, one area multiply
// stage, FRAC_BITS + 1 divider stages and one output register. The whole pipe
// stalls while out_valid is high and out_ready low.
`default_nettype none
module rect_overlap_ratio_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire rora_pkg::req_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output rora_pkg::rsp_t      out_data
);
	localparam int CB = rora_pkg::COORD_BITS;
	localparam int HB = rora_pkg::HULL_BITS;
	localparam int AB = rora_pkg::AREA_BITS;
	localparam int PB = 2 * HB;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: edges
	logic          v_s1;
	logic [CB-1:0] il_s1, it_s1, hl_s1, ht_s1;
	logic [HB-1:0] ir_s1, ib_s1, hr_s1, hb_s1;
	logic          same_s1;
	logic [HB-1:0] ar, ab, br, bb;

	always_comb begin
		ar = HB'(in_data.a_left) + HB'(in_data.a_width);
		ab = HB'(in_data.a_top) + HB'(in_data.a_height);
		br = HB'(in_data.b_left) + HB'(in_data.b_width);
		bb = HB'(in_data.b_top) + HB'(in_data.b_height);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			il_s1 <= (in_data.a_left > in_data.b_left) ? in_data.a_left : in_data.b_left;
			it_s1 <= (in_data.a_top > in_data.b_top) ? in_data.a_top : in_data.b_top;
			hl_s1 <= (in_data.a_left < in_data.b_left) ? in_data.a_left : in_data.b_left;
			ht_s1 <= (in_data.a_top < in_data.b_top) ? in_data.a_top : in_data.b_top;
			ir_s1 <= (ar < br) ? ar : br;
			ib_s1 <= (ab < bb) ? ab : bb;
			hr_s1 <= (ar > br) ? ar : br;
			hb_s1 <= (ab > bb) ? ab : bb;
			same_s1 <= (in_data.a_left == in_data.b_left) && (in_data.a_top == in_data.b_top)
				&& (in_data.a_width == in_data.b_width)
				&& (in_data.a_height == in_data.b_height);
		end
	end

	// stage 2: sizes
	logic            v_s2;
	rora_pkg::geom_t g_s2;
	logic            hit;
	logic [HB-1:0]   iw_full, ih_full;

	always_comb begin
		hit     = (ir_s1 >= HB'(il_s1)) && (ib_s1 >= HB'(it_s1));
		iw_full = ir_s1 - HB'(il_s1);
		ih_full = ib_s1 - HB'(it_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s2.inter_left   <= hit ? il_s1 : '0;
			g_s2.inter_top    <= hit ? it_s1 : '0;
			g_s2.inter_width  <= hit ? iw_full[CB-1:0] : '0;
			g_s2.inter_height <= hit ? ih_full[CB-1:0] : '0;
			g_s2.hull_left    <= hl_s1;
			g_s2.hull_top     <= ht_s1;
			g_s2.hull_width   <= hr_s1 - HB'(hl_s1);
			g_s2.hull_height  <= hb_s1 - HB'(ht_s1);
			g_s2.same_rect    <= same_s1;
		end
	end

	// stage 3: areas plus one
	logic            v_s3;
	rora_pkg::geom_t g_s3;
	logic [AB-1:0]   num_s3, den_s3;
	logic [PB-1:0]   inter_area, hull_area;

	always_comb begin
		inter_area = PB'(g_s2.inter_width) * PB'(g_s2.inter_height);
		hull_area  = PB'(g_s2.hull_width) * PB'(g_s2.hull_height);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= AB'(inter_area) + AB'(1);
			den_s3 <= AB'(hull_area) + AB'(1);
			g_s3   <= g_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	logic                            dv;
	logic [rora_pkg::RATIO_BITS-1:0] dq;
	rora_pkg::geom_t                 dg;

	rora_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (num_s3),
		.den       (den_s3),
		.in_geom   (g_s3),
		.out_valid (dv),
		.quo       (dq),
		.out_geom  (dg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.inter_left    <= dg.inter_left;
			out_data.inter_top     <= dg.inter_top;
			out_data.inter_width   <= dg.inter_width;
			out_data.inter_height  <= dg.inter_height;
			out_data.hull_left     <= dg.hull_left;
			out_data.hull_top      <= dg.hull_top;
			out_data.hull_width    <= dg.hull_width;
			out_data.hull_height   <= dg.hull_height;
			out_data.overlap_ratio <= dq;
			out_data.same_rect     <= dg.same_rect;
		end
	end
endmodule
`default_nettype wire

### tb/sv/rect_overlap_ratio_checker.sv
// Watches both channels of the rectangle overlap ratio unit, computes the
// expected response of each accepted request and compares. Depends on rora_pkg.
`default_nettype none
module rect_overlap_ratio_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_ready,
	input  wire rora_pkg::req_t in_data,
	input  wire logic           out_valid,
	input  wire logic           out_ready,
	input  wire rora_pkg::rsp_t out_data,
	output int                  fail_count,
	output int                  pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = rora_pkg::COORD_BITS;
	localparam int HB = rora_pkg::HULL_BITS;
	localparam int RB = rora_pkg::RATIO_BITS;

	rora_pkg::rsp_t expected_rsps[$];

	// restoring division, num <= den
	function automatic logic [RB-1:0] ratio_of(logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		logic [63:0] rem;
		q = 0;
		rem = num;
		if (rem >= den) begin
			q = 1;
			rem = rem - den;
		end
		for (int i = 0; i < rora_pkg::FRAC_BITS; i++) begin
			if (rem >= den - rem) begin
				rem = 2 * rem - den;
				q = (q << 1) | 1;
			end else begin
				rem = rem << 1;
				q = q << 1;
			end
		end
		return q[RB-1:0];
	endfunction

	function automatic rora_pkg::rsp_t overlap_of(rora_pkg::req_t r);
		rora_pkg::rsp_t o;
		logic [63:0] ar, ab, br, bb, il, it, ir, ib, iw, ih, hl, ht, hw, hh;
		ar = r.a_left + 64'(r.a_width);
		ab = r.a_top + 64'(r.a_height);
		br = r.b_left + 64'(r.b_width);
		bb = r.b_top + 64'(r.b_height);
		il = (r.a_left > r.b_left) ? r.a_left : r.b_left;
		it = (r.a_top > r.b_top) ? r.a_top : r.b_top;
		ir = (ar < br) ? ar : br;
		ib = (ab < bb) ? ab : bb;
		hl = (r.a_left < r.b_left) ? r.a_left : r.b_left;
		ht = (r.a_top < r.b_top) ? r.a_top : r.b_top;
		hw = ((ar > br) ? ar : br) - hl;
		hh = ((ab > bb) ? ab : bb) - ht;
		iw = 0;
		ih = 0;
		if (ir >= il && ib >= it) begin
			iw = ir - il;
			ih = ib - it;
		end else begin
			il = 0;
			it = 0;
		end
		o.inter_left    = il[CB-1:0];
		o.inter_top     = it[CB-1:0];
		o.inter_width   = iw[CB-1:0];
		o.inter_height  = ih[CB-1:0];
		o.hull_left     = hl[CB-1:0];
		o.hull_top      = ht[CB-1:0];
		o.hull_width    = hw[HB-1:0];
		o.hull_height   = hh[HB-1:0];
		o.overlap_ratio = ratio_of(iw * ih + 1, hw * hh + 1);
		o.same_rect     = (r.a_left == r.b_left && r.a_top == r.b_top &&
			r.a_width == r.b_width && r.a_height == r.b_height);
		return o;
	endfunction

	always @(posedge clk) begin
		rora_pkg::rsp_t exp_rsp;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_rsps.push_back(overlap_of(in_data));
			if (out_valid && out_ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%t: response with no request pending: %h", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (exp_rsp !== out_data) begin
						$display("%t: mismatch expected %p actual %p", $time, exp_rsp, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= expected_rsps.size();
		end
	end

	initial begin
		fail_count = 0;
		pending_count = 0;
	end
endmodule
`default_nettype wire

### tb/sv/rect_overlap_ratio_unit_tb.sv
// Stimulus and verdict for the rectangle overlap ratio unit.
// Depends on rora_pkg, rect_overlap_ratio_unit and rect_overlap_ratio_checker.
`default_nettype none
module rect_overlap_ratio_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB        = rora_pkg::COORD_BITS;
	localparam int LATENCY   = rora_pkg::FRAC_BITS + 5;
	localparam int MAX_CYCLE = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	rora_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	rora_pkg::rsp_t out_data;
	int   fail_count;
	int   pending_count;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   cycle_count;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	rect_overlap_ratio_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	rect_overlap_ratio_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLE) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);

	function automatic logic [CB-1:0] rand_coord();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return CB'($urandom_range(15));
			3: return CB'($urandom_range(32767, 32700));
			default: return CB'($urandom);
		endcase
	endfunction

	function automatic rora_pkg::req_t rand_rects();
		rora_pkg::req_t r;
		r.a_left = rand_coord();
		r.a_top = rand_coord();
		r.a_width = rand_coord();
		r.a_height = rand_coord();
		case ($urandom_range(3))
			0: begin
				r.b_left = r.a_left;
				r.b_top = r.a_top;
				r.b_width = r.a_width;
				r.b_height = r.a_height;
				if ($urandom_range(1))
					r.b_height = r.a_height ^ CB'(1 << $urandom_range(CB - 1));
			end
			1: begin
				// neighbor offset by up to 100 on each axis; may overlap, touch or lie apart
				r.b_left = CB'(r.a_left + $urandom_range(200) - 100);
				r.b_top = CB'(r.a_top + $urandom_range(200) - 100);
				r.b_width = CB'($urandom_range(200));
				r.b_height = CB'($urandom_range(200));
			end
			default: begin
				r.b_left = rand_coord();
				r.b_top = rand_coord();
				r.b_width = rand_coord();
				r.b_height = rand_coord();
			end
		endcase
		return r;
	endfunction

	task automatic send_request(rora_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_directed();
		rora_pkg::req_t r;
		r = '0;
		send_request(r);
		send_request('1);
		r = '{a_left: 10, a_top: 10, a_width: 10, a_height: 10,
			b_left: 100, b_top: 100, b_width: 5, b_height: 5};
		send_request(r);
		// touching edges
		r = '{a_left: 10, a_top: 10, a_width: 10, a_height: 10,
			b_left: 20, b_top: 12, b_width: 5, b_height: 5};
		send_request(r);
		r = '{a_left: 10, a_top: 10, a_width: 10, a_height: 10,
			b_left: 12, b_top: 20, b_width: 5, b_height: 5};
		send_request(r);
		// nested and identical
		r = '{a_left: 0, a_top: 0, a_width: 100, a_height: 100,
			b_left: 10, b_top: 10, b_width: 20, b_height: 20};
		send_request(r);
		r = '{a_left: 7, a_top: 9, a_width: 30, a_height: 40,
			b_left: 7, b_top: 9, b_width: 30, b_height: 40};
		send_request(r);
		// full-size hull
		r = '{a_left: 0, a_top: 0, a_width: 32767, a_height: 32767,
			b_left: 32767, b_top: 32767, b_width: 32767, b_height: 32767};
		send_request(r);
		r = '{a_left: 0, a_top: 0, a_width: 32767, a_height: 32767,
			b_left: 0, b_top: 0, b_width: 32767, b_height: 32767};
		send_request(r);
		r = '{a_left: 32767, a_top: 0, a_width: 0, a_height: 32767,
			b_left: 0, b_top: 32767, b_width: 32767, b_height: 0};
		send_request(r);
	endtask

	initial begin
		cycle_count = 0;
		send_idle_pct = 18;
		recv_idle_pct = 70;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_directed();
		for (int i = 0; i < 1850; i++) begin
			if (i == 600) begin
				send_idle_pct = 70;
				recv_idle_pct = 18;
			end else if (i == 1200) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (i % 150 == 75)
				recv_idle_pct = (i < 1200) ? recv_idle_pct : 0;
			send_request(rand_rects());
		end
		in_valid <= 0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
